@@ sv/gprm_pkg.sv @@
// ----------------------------------------------------------------------------
// gprm_pkg: shared definitions of the guard pattern run matcher
// Widths, reset values, register indexes and the structures that travel
// between the run counter front end and the window test pipeline.
// ----------------------------------------------------------------------------
package gprm_pkg;

	localparam int COL_W          = 12;
	localparam int MAX_ROW_WIDTH  = 4096;
	localparam int CNT_W          = 13;
	localparam int MAX_ELEMENTS   = 9;
	localparam int MAX_BACK_STEPS = 3;
	localparam int ELEM_W         = 4;
	localparam int WIDTHS_W       = ELEM_W * MAX_ELEMENTS;
	localparam int IDX_W          = $clog2(MAX_ELEMENTS);
	localparam int STEP_W         = $clog2(MAX_BACK_STEPS + 1);
	localparam int TAG_W          = 3;
	localparam int Q_DEPTH        = 2;
	localparam int QCNT_W         = $clog2(Q_DEPTH + 1);

	// Sum of runs, sum of pattern widths and the cross products.
	localparam int TOT_W  = CNT_W + $clog2(MAX_ELEMENTS);
	localparam int LEN_W  = ELEM_W + $clog2(MAX_ELEMENTS);
	localparam int PROD_W = CNT_W + LEN_W;
	localparam int DSUM_W = PROD_W + $clog2(MAX_ELEMENTS);
	localparam int TL_W   = TOT_W + LEN_W;
	localparam int CMP_W  = DSUM_W + 7;

	// Per-element limit: DEV_DEN * dev <= DEV_NUM * total (0.8 unit).
	localparam int DEV_NUM  = 4;
	localparam int DEV_DEN  = 5;
	// Mean limit: MEAN_DEN * sum < MEAN_NUM * total * length (0.42 unit).
	localparam int MEAN_NUM = 42;
	localparam int MEAN_DEN = 100;

	localparam logic [COL_W-1:0]    COL_LAST     = COL_W'(MAX_ROW_WIDTH - 1);
	localparam logic [CNT_W-1:0]    RUN_MAX      = '1;
	localparam logic [WIDTHS_W-1:0] WIDTHS_RESET = WIDTHS_W'(36'd823202072);
	localparam logic [IDX_W-1:0]    COUNT_RESET  = IDX_W'(8);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_WIDTHS = 1'b0,
		REG_PATTERN_COUNT  = 1'b1
	} cfg_reg_t;

	typedef logic [CNT_W-1:0] run_t;
	typedef run_t [MAX_ELEMENTS-1:0] runs_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             test;
		logic             last;
		logic [COL_W-1:0] spos;
		logic [COL_W-1:0] epos;
		logic [IDX_W-1:0] n;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [TAG_W-1:0] tag;
	} kill_t;

	typedef struct packed {
		logic             found;
		logic [COL_W-1:0] spos;
		logic [COL_W-1:0] epos;
	} result_t;

endpackage

@@ sv/gprm_tester.sv @@
// ----------------------------------------------------------------------------
// gprm_tester: window test pipeline
// Three register stages check a snapshot of run lengths against the
// pattern widths by exact cross-multiplication and flag a match.
// ----------------------------------------------------------------------------
module gprm_tester (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [gprm_pkg::WIDTHS_W-1:0] widths,
	input  logic                          req_valid,
	input  gprm_pkg::req_t                req,
	input  gprm_pkg::runs_t               runs,
	output logic                          res_valid,
	output gprm_pkg::req_t                res_req,
	output logic                          res_match,
	output gprm_pkg::kill_t               kill
);

	localparam int DEV_W = gprm_pkg::PROD_W + 3;

	logic                                valid_s2, valid_s3, valid_s4;
	gprm_pkg::req_t                      req_s2, req_s3, req_s4;
	gprm_pkg::runs_t                     cm_s2;
	logic [gprm_pkg::ELEM_W-1:0]         pw_s2 [gprm_pkg::MAX_ELEMENTS];
	logic [gprm_pkg::TOT_W-1:0]          tot_s2, tot_s3;
	logic [gprm_pkg::LEN_W-1:0]          len_s2;
	logic [gprm_pkg::PROD_W-1:0]         a_s3 [gprm_pkg::MAX_ELEMENTS];
	logic [gprm_pkg::PROD_W-1:0]         b_s3 [gprm_pkg::MAX_ELEMENTS];
	logic [gprm_pkg::TL_W-1:0]           tl_s3, tl_s4;
	logic                                gate_s3, ok_s4;
	logic [gprm_pkg::DSUM_W-1:0]         dsum_s4;

	gprm_pkg::runs_t                     cm_c;
	logic [gprm_pkg::ELEM_W-1:0]         pw_c [gprm_pkg::MAX_ELEMENTS];
	logic [gprm_pkg::TOT_W-1:0]          tot_c;
	logic [gprm_pkg::LEN_W-1:0]          len_c;
	logic [gprm_pkg::PROD_W-1:0]         diff_c [gprm_pkg::MAX_ELEMENTS];
	logic                                ok_c;
	logic [gprm_pkg::DSUM_W-1:0]         dsum_c;
	logic [gprm_pkg::CMP_W-1:0]          mean_lhs, mean_rhs;

	// Stage two input: mask the elements beyond the window and sum.
	always_comb begin
		tot_c = '0;
		len_c = '0;
		for (int i = 0; i < gprm_pkg::MAX_ELEMENTS; i++) begin
			if (gprm_pkg::IDX_W'(i) < req.n) begin
				cm_c[i] = runs[i];
				pw_c[i] = widths[i*gprm_pkg::ELEM_W +: gprm_pkg::ELEM_W];
			end else begin
				cm_c[i] = '0;
				pw_c[i] = '0;
			end
			tot_c = tot_c + gprm_pkg::TOT_W'(cm_c[i]);
			len_c = len_c + gprm_pkg::LEN_W'(pw_c[i]);
		end
	end

	// Stage four input: absolute deviations, per-element limit and their sum.
	always_comb begin
		ok_c   = gate_s3;
		dsum_c = '0;
		for (int i = 0; i < gprm_pkg::MAX_ELEMENTS; i++) begin
			diff_c[i] = (a_s3[i] > b_s3[i]) ? (a_s3[i] - b_s3[i]) : (b_s3[i] - a_s3[i]);
			if (DEV_W'(diff_c[i]) * DEV_W'(gprm_pkg::DEV_DEN) >
			    DEV_W'(tot_s3) * DEV_W'(gprm_pkg::DEV_NUM))
				ok_c = 1'b0;
			dsum_c = dsum_c + gprm_pkg::DSUM_W'(diff_c[i]);
		end
	end

	assign mean_lhs  = gprm_pkg::CMP_W'(dsum_s4) * gprm_pkg::CMP_W'(gprm_pkg::MEAN_DEN);
	assign mean_rhs  = gprm_pkg::CMP_W'(tl_s4) * gprm_pkg::CMP_W'(gprm_pkg::MEAN_NUM);
	assign res_match = valid_s4 && req_s4.test && ok_s4 && (mean_lhs < mean_rhs);
	assign res_valid = valid_s4;
	assign res_req   = req_s4;

	// A match ends its row: later work of the same row still in flight is dropped.
	assign kill.hit = en && res_match;
	assign kill.tag = req_s4.tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= req_valid && !(kill.hit && req.tag == kill.tag);
			valid_s3 <= valid_s2 && !(kill.hit && req_s2.tag == kill.tag);
			valid_s4 <= valid_s3 && !(kill.hit && req_s3.tag == kill.tag);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2  <= req;
			cm_s2   <= cm_c;
			pw_s2   <= pw_c;
			tot_s2  <= tot_c;
			len_s2  <= len_c;

			req_s3  <= req_s2;
			for (int i = 0; i < gprm_pkg::MAX_ELEMENTS; i++) begin
				a_s3[i] <= gprm_pkg::PROD_W'(cm_s2[i]) * gprm_pkg::PROD_W'(len_s2);
				b_s3[i] <= gprm_pkg::PROD_W'(pw_s2[i]) * gprm_pkg::PROD_W'(tot_s2);
			end
			tl_s3   <= gprm_pkg::TL_W'(tot_s2) * gprm_pkg::TL_W'(len_s2);
			tot_s3  <= tot_s2;
			gate_s3 <= (len_s2 != '0) && (tot_s2 >= gprm_pkg::TOT_W'(len_s2));

			req_s4  <= req_s3;
			ok_s4   <= ok_c;
			dsum_s4 <= dsum_c;
			tl_s4   <= tl_s3;
		end
	end

endmodule

@@ sv/guard_pattern_run_matcher.sv @@
// ----------------------------------------------------------------------------
// guard_pattern_run_matcher: guard pattern finder for one scan row
// Path: a result reaches the output register from the pixel that decides it
// through the window test pipeline (three stages after the run counter
// register). Throughput: one pixel per cycle, set by the run
// counter update; input stalls only while the two-entry result queue is full.
// Reset: configuration takes its default pattern, the row is idle until a
// pixel flagged row_first arrives, and the result queue is empty.
// ----------------------------------------------------------------------------
module guard_pattern_run_matcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           pixel,
	input  logic                           row_first,
	input  logic                           row_last,
	input  logic [gprm_pkg::COL_W-1:0]     start_column,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [gprm_pkg::COL_W-1:0]     start_pos,
	output logic [gprm_pkg::COL_W-1:0]     end_pos,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gprm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gprm_pkg::WIDTHS_W-1:0]  cfg_data
);

	// Configuration registers.
	logic [gprm_pkg::WIDTHS_W-1:0]       widths_q;
	logic [gprm_pkg::IDX_W-1:0]          count_q;

	// Row and run state.
	gprm_pkg::runs_t                     runs_q;
	logic [gprm_pkg::IDX_W-1:0]          idx_q;
	logic                                wht_q, done_q, srch_q;
	logic [gprm_pkg::COL_W-1:0]          org_q, col_q, held_q;
	logic [gprm_pkg::MAX_BACK_STEPS-1:0] hist_q;
	logic [gprm_pkg::TAG_W-1:0]          tag_q;

	// State after a row start is applied.
	gprm_pkg::runs_t                     runs_e;
	logic [gprm_pkg::IDX_W-1:0]          idx_e;
	logic                                wht_e, done_e, srch_e;
	logic [gprm_pkg::COL_W-1:0]          org_e, col_e, held_e;
	logic [gprm_pkg::MAX_BACK_STEPS-1:0] hist_e;
	logic [gprm_pkg::TAG_W-1:0]          tag_e;

	// Next state.
	gprm_pkg::runs_t                     nx_runs;
	logic [gprm_pkg::IDX_W-1:0]          nx_idx;
	logic                                nx_wht, nx_done, nx_srch;
	logic [gprm_pkg::COL_W-1:0]          nx_org, nx_col;
	logic [gprm_pkg::MAX_BACK_STEPS-1:0] nx_hist;

	logic [gprm_pkg::IDX_W-1:0]          n_c, idx_c;
	logic [gprm_pkg::COL_W-1:0]          ps, fs, fe;
	logic [gprm_pkg::STEP_W-1:0]         d;
	logic                                p, ft, et, req_v;
	gprm_pkg::runs_t                     fsnap, snap;
	gprm_pkg::req_t                      nx_req;

	// Request register in front of the test pipeline.
	logic                                valid_s1;
	gprm_pkg::req_t                      req_s1;
	gprm_pkg::runs_t                     runs_s1;

	logic                                t_valid, t_match, push_want, push, pop, en;
	logic                                in_fire, kill_cur;
	gprm_pkg::req_t                      t_req;
	gprm_pkg::kill_t                     kill;
	gprm_pkg::result_t                   res_c, q0_q, q1_q;
	logic [gprm_pkg::QCNT_W-1:0]         q_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widths_q <= gprm_pkg::WIDTHS_RESET;
			count_q  <= gprm_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			case (gprm_pkg::cfg_reg_t'(cfg_index))
				gprm_pkg::REG_PATTERN_WIDTHS: widths_q <= cfg_data;
				gprm_pkg::REG_PATTERN_COUNT:  count_q  <= cfg_data[gprm_pkg::IDX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q < gprm_pkg::IDX_W'(2))
			n_c = gprm_pkg::IDX_W'(2);
		else if (count_q > gprm_pkg::IDX_W'(gprm_pkg::MAX_ELEMENTS))
			n_c = gprm_pkg::IDX_W'(gprm_pkg::MAX_ELEMENTS);
		else
			n_c = count_q;
	end

	assign kill_cur = kill.hit && (kill.tag == tag_q);
	assign in_fire  = in_valid && in_ready;

	// Run counting for one pixel.
	always_comb begin
		runs_e  = row_first ? '0 : runs_q;
		idx_e   = row_first ? '0 : idx_q;
		wht_e   = row_first ? 1'b0 : wht_q;
		srch_e  = row_first ? 1'b0 : srch_q;
		org_e   = row_first ? '0 : org_q;
		col_e   = row_first ? '0 : col_q;
		held_e  = row_first ? start_column : held_q;
		hist_e  = row_first ? '0 : hist_q;
		tag_e   = row_first ? gprm_pkg::TAG_W'(tag_q + 1'b1) : tag_q;
		done_e  = row_first ? 1'b0 : (done_q || kill_cur);

		nx_runs = runs_e;
		nx_idx  = idx_e;
		nx_wht  = wht_e;
		nx_srch = srch_e;
		nx_org  = org_e;
		nx_col  = col_e;
		nx_hist = hist_e;
		nx_done = done_e;

		ft      = 1'b0;
		et      = 1'b0;
		req_v   = 1'b0;
		fsnap   = runs_e;
		fs      = org_e;
		fe      = col_e;
		idx_c   = (idx_e > gprm_pkg::IDX_W'(gprm_pkg::MAX_ELEMENTS - 1)) ?
		          gprm_pkg::IDX_W'(gprm_pkg::MAX_ELEMENTS - 1) : idx_e;

		// Step back from the start column over black pixels of this row.
		ps = col_e;
		d  = '0;
		p  = pixel;
		for (int j = 0; j < gprm_pkg::MAX_BACK_STEPS; j++) begin
			if (p && ps != '0) begin
				ps = ps - 1'b1;
				d  = d + 1'b1;
				p  = hist_e[j];
			end
		end

		if (!done_e) begin
			if (srch_e) begin
				nx_idx = idx_c;
				if (pixel != wht_e) begin
					if (runs_e[idx_c] != gprm_pkg::RUN_MAX)
						nx_runs[idx_c] = runs_e[idx_c] + 1'b1;
				end else if (idx_c >= n_c - 1'b1) begin
					// Window complete: test it and slide by one bar/space pair.
					ft     = 1'b1;
					nx_org = org_e + gprm_pkg::COL_W'(runs_e[0]) + gprm_pkg::COL_W'(runs_e[1]);
					for (int i = 0; i < gprm_pkg::MAX_ELEMENTS; i++) begin
						if (i + 2 < gprm_pkg::MAX_ELEMENTS && gprm_pkg::IDX_W'(i + 2) < n_c)
							nx_runs[i] = runs_e[(i + 2) % gprm_pkg::MAX_ELEMENTS];
						else
							nx_runs[i] = '0;
					end
					nx_idx          = n_c - gprm_pkg::IDX_W'(2);
					nx_runs[nx_idx] = gprm_pkg::CNT_W'(1);
					nx_wht          = !wht_e;
				end else begin
					nx_idx          = gprm_pkg::IDX_W'(idx_c + 1'b1);
					nx_runs[nx_idx] = gprm_pkg::CNT_W'(1);
					nx_wht          = !wht_e;
				end
			end else if (col_e == held_e) begin
				// Replay of the stepped-back pixels: a landing pixel, then blacks.
				nx_srch = 1'b1;
				nx_org  = ps;
				nx_wht  = 1'b0;
				if (p) begin
					nx_runs[0] = gprm_pkg::CNT_W'(d) + 1'b1;
					nx_idx     = '0;
				end else if (d == '0) begin
					nx_runs[1] = gprm_pkg::CNT_W'(1);
					nx_idx     = gprm_pkg::IDX_W'(1);
					nx_wht     = 1'b1;
				end else if (n_c == gprm_pkg::IDX_W'(2)) begin
					// The first black closes a complete two-element window.
					ft         = 1'b1;
					fsnap      = '0;
					fsnap[1]   = gprm_pkg::CNT_W'(1);
					fs         = ps;
					fe         = ps + 1'b1;
					nx_org     = ps + 1'b1;
					nx_runs[0] = gprm_pkg::CNT_W'(d);
					nx_idx     = '0;
				end else begin
					nx_runs[1] = gprm_pkg::CNT_W'(1);
					nx_runs[2] = gprm_pkg::CNT_W'(d);
					nx_idx     = gprm_pkg::IDX_W'(2);
				end
			end
			nx_hist = gprm_pkg::MAX_BACK_STEPS'({hist_e, pixel});
			nx_col  = (col_e == gprm_pkg::COL_LAST) ? '0 : col_e + 1'b1;
			et      = row_last && nx_srch && (nx_idx >= n_c - 1'b1);
			req_v   = ft || row_last;
			if (row_last)
				nx_done = 1'b1;
		end

		snap        = ft ? fsnap : nx_runs;
		nx_req.tag  = tag_e;
		nx_req.test = ft || et;
		nx_req.last = row_last;
		nx_req.spos = ft ? fs : nx_org;
		nx_req.epos = ft ? fe : col_e;
		nx_req.n    = n_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q <= '0;
			idx_q  <= '0;
			wht_q  <= 1'b0;
			srch_q <= 1'b0;
			org_q  <= '0;
			col_q  <= '0;
			held_q <= '0;
			hist_q <= '0;
			tag_q  <= '0;
			done_q <= 1'b1;
		end else if (in_fire) begin
			runs_q <= nx_runs;
			idx_q  <= nx_idx;
			wht_q  <= nx_wht;
			srch_q <= nx_srch;
			org_q  <= nx_org;
			col_q  <= nx_col;
			held_q <= held_e;
			hist_q <= nx_hist;
			tag_q  <= tag_e;
			done_q <= nx_done;
		end else if (kill_cur) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_fire && !done_e && req_v;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1  <= nx_req;
			runs_s1 <= snap;
		end
	end

	gprm_tester u_tester (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.widths    (widths_q),
		.req_valid (valid_s1),
		.req       (req_s1),
		.runs      (runs_s1),
		.res_valid (t_valid),
		.res_req   (t_req),
		.res_match (t_match),
		.kill      (kill)
	);

	// A failed test only reports when it also ends the row.
	assign push_want = t_valid && (t_match || t_req.last);
	assign pop       = out_valid && out_ready;
	assign en        = !push_want || (q_cnt_q != gprm_pkg::QCNT_W'(gprm_pkg::Q_DEPTH)) || pop;
	assign push      = en && push_want;
	assign in_ready  = en;

	assign res_c.found = t_match;
	assign res_c.spos  = t_match ? t_req.spos : '0;
	assign res_c.epos  = t_match ? t_req.epos : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			q_cnt_q <= '0;
		else if (push && !pop)
			q_cnt_q <= q_cnt_q + 1'b1;
		else if (pop && !push)
			q_cnt_q <= q_cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (q_cnt_q == '0)
					q0_q <= res_c;
				else
					q1_q <= res_c;
			end
			2'b01: q0_q <= q1_q;
			2'b11: begin
				if (q_cnt_q == gprm_pkg::QCNT_W'(1)) begin
					q0_q <= res_c;
				end else begin
					q0_q <= q1_q;
					q1_q <= res_c;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = (q_cnt_q != '0);
	assign found     = q0_q.found;
	assign start_pos = q0_q.spos;
	assign end_pos   = q0_q.epos;

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> start_pos == '0 && end_pos == '0)
		else $error("not-found result carries nonzero positions");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_cnt_q == gprm_pkg::QCNT_W'(gprm_pkg::Q_DEPTH))
		else $error("input stalled while the result queue has room");

	a_row_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && row_last |=> done_q)
		else $error("row still active after its last pixel");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= gprm_pkg::QCNT_W'(gprm_pkg::Q_DEPTH))
		else $error("result queue overflow");

endmodule

@@ test/tb_guard_pattern_run_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_guard_pattern_run_matcher: self-checking bench of the guard pattern finder
// Pixel rows go in through a valid/ready channel with random bursts and gaps.
// The rows found are checked against a behavioral model of the row search.
// A short table of directed rows comes first, then random rows under several
// pattern settings, rows reconfigured part way, and one very long row.
// The result side stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_guard_pattern_run_matcher;

	import gprm_pkg::*;

	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam logic [WIDTHS_W-1:0] STOP_WIDTHS = 36'h1_2111_3117;

	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_NONE,
		CHK_ROW
	} row_check_t;

	typedef struct packed {
		bit               pix;
		bit               first;
		bit               last;
		logic [COL_W-1:0] sc;
	} px_t;

	typedef struct packed {
		bit               pix;
		bit               first;
		bit               last;
		logic [COL_W-1:0] sc;
		row_check_t       chk;
		bit               found;
		logic [COL_W-1:0] spos;
		logic [COL_W-1:0] epos;
	} dir_step_t;

	// Idle pixel, a one-pixel row, a full default guard reached by stepping
	// back three black pixels, a pixel after the match, and a row abandoned
	// by a new row whose start column is never reached.
	localparam dir_step_t DIRECTED [25] = '{
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_NONE,  1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b1, 1'b1, 12'd0,    CHK_ROW,   1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b1, 1'b0, 12'd4,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b0, 1'b0, 12'd0,    CHK_MODEL, 1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b0, 12'd0,    CHK_ROW,   1'b1, 12'd1, 12'd18},
		'{1'b1, 1'b0, 1'b1, 12'd0,    CHK_NONE,  1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b1, 1'b0, 12'hFFF,  CHK_NONE,  1'b0, 12'd0, 12'd0},
		'{1'b0, 1'b1, 1'b0, 12'hFFF,  CHK_NONE,  1'b0, 12'd0, 12'd0},
		'{1'b1, 1'b0, 1'b1, 12'd0,    CHK_ROW,   1'b0, 12'd0, 12'd0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                pixel = 1'b0;
	logic                row_first = 1'b0;
	logic                row_last = 1'b0;
	logic [COL_W-1:0]    start_column = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                found;
	logic [COL_W-1:0]    start_pos;
	logic [COL_W-1:0]    end_pos;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_reg_t            cfg_index = REG_PATTERN_WIDTHS;
	logic [WIDTHS_W-1:0] cfg_data = '0;

	guard_pattern_run_matcher u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.row_first    (row_first),
		.row_last     (row_last),
		.start_column (start_column),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Row search model state.
	logic [WIDTHS_W-1:0] widths_reg = WIDTHS_RESET;
	logic [3:0]          count_reg = 4'd8;
	logic [CNT_W-1:0]    run_len [MAX_ELEMENTS];
	int unsigned         run_pos = 0;
	bit                  in_space = 1'b0;
	logic [COL_W-1:0]    origin_col = '0;
	logic [COL_W-1:0]    next_col = '0;
	logic [COL_W-1:0]    held_col = '0;
	logic [MAX_BACK_STEPS-1:0] recent_px = '0;
	bit                  row_idle = 1'b1;
	bit                  scanning = 1'b0;

	result_t     expected_rows [$];
	result_t     want;
	px_t         row_px [$];
	int unsigned active_px = 0;
	int unsigned burst_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          hold_req = 1'b0;

	initial begin
		foreach (run_len[i]) run_len[i] = '0;
	end

	function automatic int unsigned window_len();
		int unsigned n;
		n = count_reg;
		if (n < 2) n = 2;
		if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
		return n;
	endfunction

	function automatic longint unsigned module_width(int unsigned i);
		if (i >= MAX_ELEMENTS) return 0;
		return longint'((widths_reg >> (ELEM_W * i)) & 36'hF);
	endfunction

	// Exact form of the 0.8 per-element and 0.42 mean deviation limits.
	function automatic bit window_fits(int unsigned n);
		longint unsigned t, l, sum, a, b, d;
		t = 0;
		l = 0;
		sum = 0;
		for (int unsigned i = 0; i < n; i++) begin
			t += run_len[i];
			l += module_width(i);
		end
		if (l == 0 || t < l) return 1'b0;
		for (int unsigned i = 0; i < n; i++) begin
			a = run_len[i] * l;
			b = module_width(i) * t;
			d = (a > b) ? a - b : b - a;
			if (5 * d > 4 * t) return 1'b0;
			sum += d;
		end
		return (100 * sum < 42 * t * l);
	endfunction

	function automatic bit take_run(bit black, int unsigned x,
			output logic [COL_W-1:0] s, output logic [COL_W-1:0] e);
		int unsigned n;
		n = window_len();
		s = origin_col;
		e = COL_W'(x);
		if (run_pos >= MAX_ELEMENTS) run_pos = MAX_ELEMENTS - 1;
		if (black != in_space) begin
			if (run_len[run_pos] < RUN_MAX) run_len[run_pos]++;
			return 1'b0;
		end
		if (run_pos >= n - 1) begin
			if (window_fits(n)) return 1'b1;
			// Slide the window by one bar/space pair.
			origin_col = COL_W'(origin_col + run_len[0] + run_len[1]);
			for (int unsigned i = 0; i + 2 < n; i++) run_len[i] = run_len[i + 2];
			for (int unsigned i = n - 2; i < MAX_ELEMENTS; i++) run_len[i] = '0;
			run_pos = n - 2;
		end else begin
			run_pos++;
		end
		run_len[run_pos] = 1;
		in_space = !in_space;
		return 1'b0;
	endfunction

	function automatic bit scan_pixel(px_t p, output bit has, output result_t r);
		int unsigned x, ps, drift, n;
		bit hit, q;
		logic [COL_W-1:0] s, e;
		has = 1'b0;
		r = '0;
		hit = 1'b0;
		s = '0;
		e = '0;
		if (p.first) begin
			row_idle = 1'b0;
			scanning = 1'b0;
			next_col = '0;
			recent_px = '0;
			held_col = p.sc;
			foreach (run_len[i]) run_len[i] = '0;
			run_pos = 0;
			in_space = 1'b0;
			origin_col = '0;
		end
		if (row_idle) return 1'b0;
		x = next_col;
		if (scanning) begin
			hit = take_run(p.pix, x, s, e);
		end else if (x == held_col) begin
			// Step back over black pixels of this row to the start of the bar.
			ps = x;
			drift = 0;
			q = p.pix;
			while (q && ps > 0 && drift < MAX_BACK_STEPS) begin
				drift++;
				ps--;
				q = recent_px[x - ps - 1];
			end
			scanning = 1'b1;
			origin_col = COL_W'(ps);
			for (int unsigned col = ps; col <= x && !hit; col++) begin
				q = (col == x) ? p.pix : recent_px[x - col - 1];
				hit = take_run(q, col, s, e);
			end
		end
		recent_px = {recent_px[MAX_BACK_STEPS-2:0], p.pix};
		next_col = (x + 1 >= MAX_ROW_WIDTH) ? '0 : COL_W'(x + 1);
		n = window_len();
		if (!hit && p.last && scanning && run_pos >= n - 1 && window_fits(n)) begin
			hit = 1'b1;
			s = origin_col;
			e = COL_W'(x);
		end
		if (hit || p.last) begin
			has = 1'b1;
			r.found = hit;
			r.spos = hit ? s : '0;
			r.epos = hit ? e : '0;
			row_idle = 1'b1;
			scanning = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic px_t make_px(bit b);
		px_t p;
		p.pix = b;
		p.first = 1'b0;
		p.last = 1'b0;
		p.sc = COL_W'($urandom_range(4095));
		return p;
	endfunction

	task automatic send_px(input px_t p, output bit has, output result_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		pixel = p.pix;
		row_first = p.first;
		row_last = p.last;
		start_column = p.sc;
		do @(posedge clk); while (!in_ready);
		if (scan_pixel(p, has, r)) active_px++;
	endtask

	task automatic send_range(int unsigned from, int unsigned upto);
		bit has;
		result_t r;
		for (int unsigned k = from; k < upto; k++) begin
			send_px(row_px[k], has, r);
			if (has) expected_rows.push_back(r);
		end
	endtask

	// Mostly a guard pattern scaled and jittered, between noise; some rows
	// are noise alone, some have a broken element, a few never end.
	task automatic build_row();
		int unsigned n, len, m, total, start_at, pick;
		row_px.delete();
		n = window_len();
		start_at = 0;
		if ($urandom_range(3) == 0) begin
			len = $urandom_range(1, 40);
			repeat (len) row_px.push_back(make_px($urandom_range(1)));
		end else begin
			len = $urandom_range(0, 8);
			repeat (len) row_px.push_back(make_px($urandom_range(1)));
			if (len > 0 && $urandom_range(4) != 0) row_px[len-1].pix = 1'b0;
			start_at = len;
			total = 0;
			for (int unsigned i = 0; i < n; i++) total += module_width(i);
			m = (total == 0) ? 1 : 60 / total;
			if (m < 1) m = 1;
			if (m > 3) m = 3;
			m = $urandom_range(1, m);
			for (int unsigned i = 0; i < n; i++) begin
				len = module_width(i) * m;
				if ($urandom_range(9) < 3)
					len = (len > 1 && $urandom_range(1)) ? len - 1 : len + 1;
				if ($urandom_range(19) == 0) len = 2 * len + 1;
				repeat (len) row_px.push_back(make_px(i % 2 == 0));
			end
			row_px.push_back(make_px(n % 2 == 0));
			len = $urandom_range(0, 8);
			repeat (len) row_px.push_back(make_px($urandom_range(1)));
		end
		row_px[0].first = 1'b1;
		pick = $urandom_range(9);
		if (pick <= 5) row_px[0].sc = COL_W'(start_at + $urandom_range(0, 3));
		else if (pick == 6) row_px[0].sc = '0;
		else if (pick == 7) row_px[0].sc = COL_W'($urandom_range(0, row_px.size() - 1));
		else if (pick == 8) row_px[0].sc = COL_W'($urandom_range(4095));
		else row_px[0].sc = COL_W'(start_at + $urandom_range(4, 6));
		if ($urandom_range(19) != 0) row_px[row_px.size()-1].last = 1'b1;
	endtask

	task automatic random_rows(int unsigned amount);
		int unsigned target;
		target = active_px + amount;
		while (active_px < target) begin
			build_row();
			send_range(0, row_px.size());
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [WIDTHS_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PATTERN_WIDTHS) widths_reg = val;
		else count_reg = val[3:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: stall modes that change every so often, plus one long
	// hold-off on request so that the result queue fills and the input stalls.
	initial begin
		int unsigned mode, mode_left, rx_tick;
		mode = 0;
		mode_left = 0;
		rx_tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(3);
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			rx_tick++;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = ($urandom_range(3) != 0);
				2: out_ready = ($urandom_range(3) == 0);
				default: out_ready = (rx_tick % 4 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rows.size() == 0) begin
				$display("%0t: result with none expected: found=%0d start_pos=%0d end_pos=%0d",
					$time, found, start_pos, end_pos);
				mismatches++;
			end else begin
				want = expected_rows.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found, found);
					mismatches++;
				end
				if (start_pos !== want.spos) begin
					$display("%0t: start_pos expected %0d actual %0d",
						$time, want.spos, start_pos);
					mismatches++;
				end
				if (end_pos !== want.epos) begin
					$display("%0t: end_pos expected %0d actual %0d", $time, want.epos, end_pos);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** guard_pattern_run_matcher: FAILED **");
			$finish;
		end
	end

	initial begin
		bit has;
		result_t r;
		px_t p;
		logic [WIDTHS_W-1:0] w;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[k]) begin
			p = '{DIRECTED[k].pix, DIRECTED[k].first, DIRECTED[k].last, DIRECTED[k].sc};
			send_px(p, has, r);
			case (DIRECTED[k].chk)
				CHK_MODEL: if (has) expected_rows.push_back(r);
				CHK_ROW: expected_rows.push_back(
					'{DIRECTED[k].found, DIRECTED[k].spos, DIRECTED[k].epos});
				default: ;
			endcase
		end

		hold_req = 1'b1;
		random_rows(300);
		wait_idle();

		write_reg(REG_PATTERN_WIDTHS, STOP_WIDTHS);
		write_reg(REG_PATTERN_COUNT, 36'd9);
		random_rows(250);
		wait_idle();

		w = '0;
		for (int unsigned i = 0; i < MAX_ELEMENTS; i++) w[ELEM_W*i +: ELEM_W] = $urandom_range(1, 4);
		write_reg(REG_PATTERN_WIDTHS, w);
		write_reg(REG_PATTERN_COUNT, 36'd2);
		random_rows(200);
		wait_idle();

		// Count below the minimum acts as two elements.
		write_reg(REG_PATTERN_WIDTHS, '1);
		write_reg(REG_PATTERN_COUNT, 36'd0);
		random_rows(150);
		wait_idle();

		write_reg(REG_PATTERN_COUNT, 36'd15);
		random_rows(300);
		wait_idle();

		// A zero pattern can never match.
		write_reg(REG_PATTERN_WIDTHS, '0);
		write_reg(REG_PATTERN_COUNT, 36'd5);
		random_rows(100);
		wait_idle();

		// Shrink the window in the middle of a row.
		write_reg(REG_PATTERN_WIDTHS, STOP_WIDTHS);
		repeat (4) begin
			write_reg(REG_PATTERN_COUNT, 36'd9);
			build_row();
			send_range(0, row_px.size() / 2);
			wait_idle();
			write_reg(REG_PATTERN_COUNT, WIDTHS_W'($urandom_range(2, 4)));
			send_range(row_px.size() / 2, row_px.size());
			wait_idle();
		end

		// A bar longer than the run counter, then a short match whose columns
		// and origin have wrapped.
		write_reg(REG_PATTERN_WIDTHS, 36'h11);
		write_reg(REG_PATTERN_COUNT, 36'd2);
		row_px.delete();
		repeat (8200) row_px.push_back(make_px(1'b1));
		repeat (3) row_px.push_back(make_px(1'b0));
		repeat (2) row_px.push_back(make_px(1'b1));
		repeat (2) row_px.push_back(make_px(1'b0));
		repeat (2) row_px.push_back(make_px(1'b1));
		row_px[0].first = 1'b1;
		row_px[0].sc = '0;
		row_px[row_px.size()-1].last = 1'b1;
		send_range(0, row_px.size());
		wait_idle();

		repeat (4) begin
			w = '0;
			for (int unsigned i = 0; i < MAX_ELEMENTS; i++)
				w[ELEM_W*i +: ELEM_W] = $urandom_range(0, 4);
			write_reg(REG_PATTERN_WIDTHS, w);
			write_reg(REG_PATTERN_COUNT, WIDTHS_W'($urandom_range(0, 15)));
			random_rows(140);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("** guard_pattern_run_matcher: PASSED **");
		end else begin
			$display("** guard_pattern_run_matcher: FAILED **");
		end
		$finish;
	end

endmodule
